@@ design/srs_pkg.sv @@
package srs_pkg;

    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int WL_BITS    = 11;
    localparam int LIMIT_BITS = 15;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [WL_BITS-1:0]    WL_RESET    = 11'd1000;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd12868;

    localparam logic REG_WINDOW_LENGTH   = 1'b0;
    localparam logic REG_STABILITY_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SUM,
        ST_START,
        ST_ROOT,
        ST_OUT
    } srs_state_t;

    typedef enum logic [1:0] {
        RU_IDLE,
        RU_DIV,
        RU_SQRT
    } srs_root_state_t;

endpackage

@@ design/srs_ram.sv @@
module srs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/srs_root_unit.sv @@
module srs_root_unit #(
    parameter int SUM_W  = 41,
    parameter int LEN_W  = 11,
    parameter int ROOT_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum,
    input  logic [LEN_W-1:0]  len,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    import srs_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(SUM_W);

    srs_root_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [LEN_W-1:0]  drem_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              done_reg;

    logic [LEN_W:0]   div_shift;
    logic             div_ge;
    logic [REM_W+1:0] sq_cur;
    logic [REM_W+1:0] sq_trial;
    logic             sq_ge;
    logic             div_last;
    logic             sq_last;

    always_comb begin
        div_shift = {drem_reg, quo_reg[SUM_W-1]};
        div_ge    = div_shift >= {1'b0, len_reg};
        sq_cur    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_ge     = sq_cur >= sq_trial;
        div_last  = cnt_reg == CNT_W'(SUM_W - 1);
        sq_last   = cnt_reg == CNT_W'(ROOT_W - 1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RU_IDLE: if (start) state_next = RU_DIV;
            RU_DIV:  if (div_last) state_next = RU_SQRT;
            RU_SQRT: if (sq_last) state_next = RU_IDLE;
            default: state_next = RU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RU_SQRT) && sq_last;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            RU_IDLE: begin
                quo_reg  <= sum;
                len_reg  <= len;
                drem_reg <= '0;
                cnt_reg  <= '0;
            end
            RU_DIV: begin
                drem_reg <= div_ge ? LEN_W'(div_shift - {1'b0, len_reg}) : LEN_W'(div_shift);
                quo_reg  <= {quo_reg[SUM_W-2:0], div_ge};
                if (div_last) begin
                    cnt_reg  <= '0;
                    rad_reg  <= {quo_reg[RAD_W-2:0], div_ge};
                    srem_reg <= '0;
                    root_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            RU_SQRT: begin
                srem_reg <= sq_ge ? REM_W'(sq_cur - sq_trial) : REM_W'(sq_cur);
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/sliding_rms_stability_check.sv @@
// Sliding-window RMS with a sticky stability flag. Each input beat carries one
// signed Q3.12 sample (s_tdata) and a record-start bit (s_tuser); the last
// window_length samples are kept in a RAM delay line and their squares in a
// running sum. Once the window is full, every beat yields one result beat with
// floor(sqrt(floor(sum / window_length))) saturated to all ones, and a flag that
// stays set once any RMS of the record exceeded stability_limit. Writing
// window_length or a set start bit restarts the record. One beat is taken at a
// time: a new beat is accepted only after the last one has been squared and
// summed and, once the window is full, divided, rooted and loaded into the
// output register. The work is done by the bit-serial squarer, the restoring
// divider (one quotient bit per cycle) and the square root (one result bit per
// cycle). A finished result waits in the output register while the next beat
// is taken. A window_length of 0 counts as 1, one above MAX_WINDOW as MAX_WINDOW.
module sliding_rms_stability_check #(
    parameter int MAX_WINDOW  = srs_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = srs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // sample
    input  logic                               s_tuser,  // first
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,  // rms, unstable
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srs_pkg::APB_AW-1:0]         paddr,
    input  logic [srs_pkg::APB_DW-1:0]         pwdata,
    output logic [srs_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    import srs_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int IO_W   = ((SB + 7) / 8) * 8;
    localparam int RMS_W  = SB - 1;
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = 2 * SB - 1 + $clog2(MAX_WINDOW);
    localparam int SQ_W   = 2 * SB;
    localparam int MCNT_W = $clog2(SB);

    srs_state_t state_reg, state_next;

    logic [WL_BITS-1:0]    window_length_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [LEN_W-1:0]      fill_count_reg;
    logic [AW-1:0]         wp_reg;
    logic                  flag_reg;
    logic [SB-1:0]         sample_reg;
    logic                  has_old_reg;
    logic [SB-1:0]         mag_new_reg;
    logic [SB-1:0]         mag_old_reg;
    logic [SB-1:0]         mpl_new_reg;
    logic [SB-1:0]         mpl_old_reg;
    logic [SQ_W-1:0]       acc_new_reg;
    logic [SQ_W-1:0]       acc_old_reg;
    logic [MCNT_W-1:0]     mul_cnt_reg;
    logic [RMS_W-1:0]      rms_reg;
    logic [IO_W-1:0]       m_tdata_reg;
    logic                  m_tvalid_reg;

    logic              cfg_wr;
    logic              s_accept;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  fill_base;
    logic              has_old;
    logic [AW-1:0]     old_idx;
    logic [AW-1:0]     wp_inc;
    logic [SB-1:0]     in_sample;
    logic [SB-1:0]     ram_rdata;
    logic [SB-1:0]     old_mag;
    logic              full;
    logic              mul_last;
    logic              root_start;
    logic              root_done;
    logic [SB-1:0]     root;
    logic [RMS_W-1:0]  rms_sat;
    logic              s_tready_c;
    logic              out_load;

    function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
        return v[SB-1] ? SB'(~v + 1'b1) : v;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_STABILITY_LIMIT) ? APB_DW'(limit_reg)
                                                        : APB_DW'(window_length_reg);
    assign s_accept = s_tvalid && s_tready;
    assign in_sample = s_tdata[SB-1:0];

    always_comb begin
        if (window_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(window_length_reg) > 32'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(window_length_reg);
        end
        fill_base = s_tuser ? '0 : fill_count_reg;
        has_old   = 32'(fill_base) >= 32'(eff_len);
        if (32'(wp_reg) >= 32'(eff_len)) begin
            old_idx = AW'(32'(wp_reg) - 32'(eff_len));
        end else begin
            old_idx = AW'(32'(wp_reg) + 32'(MAX_WINDOW) - 32'(eff_len));
        end
        wp_inc   = (32'(wp_reg) == 32'(MAX_WINDOW - 1)) ? '0 : AW'(wp_reg + 1'b1);
        old_mag  = has_old_reg ? mag_of(ram_rdata) : '0;
        full     = 32'(fill_count_reg) >= 32'(eff_len);
        mul_last = mul_cnt_reg == MCNT_W'(SB - 1);
        rms_sat  = root[SB-1] ? '1 : root[RMS_W-1:0];
    end

    srs_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wp_reg),
        .wdata (in_sample),
        .raddr (old_idx),
        .rdata (ram_rdata)
    );

    srs_root_unit #(
        .SUM_W  (SUM_W),
        .LEN_W  (LEN_W),
        .ROOT_W (SB)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .sum     (sum_reg),
        .len     (eff_len),
        .done    (root_done),
        .root    (root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   if (mul_last) state_next = ST_SUM;
            ST_SUM:   state_next = full ? ST_START : ST_IDLE;
            ST_START: state_next = ST_ROOT;
            ST_ROOT:  if (root_done) state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready_c = state_reg == ST_IDLE;
        root_start = state_reg == ST_START;
        out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WL_RESET;
            limit_reg         <= LIMIT_RESET;
            sum_reg           <= '0;
            fill_count_reg    <= '0;
            wp_reg            <= '0;
            flag_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_WINDOW_LENGTH: begin
                        window_length_reg <= pwdata[WL_BITS-1:0];
                        sum_reg           <= '0;
                        fill_count_reg    <= '0;
                        flag_reg          <= 1'b0;
                    end
                    REG_STABILITY_LIMIT: begin
                        limit_reg <= pwdata[LIMIT_BITS-1:0];
                    end
                    default: begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
            if (s_accept) begin
                sample_reg     <= in_sample;
                has_old_reg    <= has_old;
                fill_count_reg <= has_old ? eff_len : LEN_W'(fill_base + 1'b1);
                wp_reg         <= wp_inc;
                if (s_tuser) begin
                    sum_reg  <= '0;
                    flag_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                ST_LOAD: begin
                    mag_new_reg <= mag_of(sample_reg);
                    mpl_new_reg <= mag_of(sample_reg);
                    mag_old_reg <= old_mag;
                    mpl_old_reg <= old_mag;
                    acc_new_reg <= '0;
                    acc_old_reg <= '0;
                    mul_cnt_reg <= '0;
                end
                ST_MUL: begin
                    acc_new_reg <= {acc_new_reg[SQ_W-2:0], 1'b0}
                                   + (mpl_new_reg[SB-1] ? SQ_W'(mag_new_reg) : '0);
                    acc_old_reg <= {acc_old_reg[SQ_W-2:0], 1'b0}
                                   + (mpl_old_reg[SB-1] ? SQ_W'(mag_old_reg) : '0);
                    mpl_new_reg <= {mpl_new_reg[SB-2:0], 1'b0};
                    mpl_old_reg <= {mpl_old_reg[SB-2:0], 1'b0};
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                end
                ST_SUM: begin
                    sum_reg <= sum_reg - SUM_W'(acc_old_reg) + SUM_W'(acc_new_reg);
                end
                ST_ROOT: begin
                    if (root_done) begin
                        rms_reg <= rms_sat;
                        if (32'(rms_sat) > 32'(limit_reg)) begin
                            flag_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                    mul_cnt_reg <= mul_cnt_reg;
                end
            endcase
            if (out_load) begin
                m_tdata_reg  <= IO_W'({flag_reg, rms_reg});
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = s_tready_c;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_count_reg) <= 32'(eff_len))
        else $error("fill count beyond window length");

    a_done_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == ST_ROOT)
        else $error("root unit finished outside root wait");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result beat raised outside output state");

    a_accept_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_LOAD)
        else $error("accepted beat did not start processing");

endmodule

@@ tb/rms_window_checker.sv @@
module rms_window_checker
    import srs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [15:0]         m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    output int                  failures,
    output int                  pending
);

    localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_LIMIT  = {REG_STABILITY_LIMIT, 2'b00};

    typedef struct packed {
        logic        unstable;
        logic [14:0] rms;
    } rms_beat_t;

    rms_beat_t rms_due[$];

    logic [WL_BITS-1:0]    win_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [15:0]           history [0:1023];
    logic [40:0]           sq_sum;
    logic [10:0]           filled;
    logic [9:0]            wr_ptr;
    logic                  flag;
    rms_beat_t             got;
    rms_beat_t             want;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic logic [31:0] squared(input logic [15:0] raw);
        logic [31:0] m;
        m = raw[15] ? 32'h10000 - {16'd0, raw} : {16'd0, raw};
        return m * m;
    endfunction

    function automatic logic [16:0] floor_root(input logic [40:0] x);
        logic [16:0] r;
        logic [16:0] t;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (17'd1 << b);
            if (longint'(t) * longint'(t) <= longint'(x))
                r = t;
        end
        return r;
    endfunction

    task automatic restart_record();
        sq_sum = '0;
        filled = '0;
        flag   = 1'b0;
    endtask

    task automatic take_sample(input logic [15:0] raw, input logic starts_record);
        logic [10:0] eff;
        logic [9:0]  old_slot;
        logic [16:0] root;
        rms_beat_t   beat;
        eff = (win_reg == 0) ? 11'd1 : ((win_reg > 11'd1024) ? 11'd1024 : win_reg);
        if (starts_record)
            restart_record();
        if (filled >= eff) begin
            old_slot = wr_ptr - eff[9:0];
            sq_sum   = sq_sum - squared(history[old_slot]);
            filled   = eff;
        end else begin
            filled = filled + 1'b1;
        end
        sq_sum          = sq_sum + squared(raw);
        history[wr_ptr] = raw;
        wr_ptr          = wr_ptr + 1'b1;
        if (filled == eff) begin
            root = floor_root(sq_sum / eff);
            beat.rms = (root > 17'd32767) ? 15'h7fff : root[14:0];
            if (beat.rms > limit_reg)
                flag = 1'b1;
            beat.unstable = flag;
            rms_due.push_back(beat);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   = WL_RESET;
            limit_reg = LIMIT_RESET;
            wr_ptr    = '0;
            restart_record();
            rms_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_WINDOW) begin
                    win_reg = pwdata[WL_BITS-1:0];
                    restart_record();
                end else if (paddr == ADDR_LIMIT) begin
                    limit_reg = pwdata[LIMIT_BITS-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (rms_due.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected beat, expected none, got rms %0d unstable %0b",
                             $time, got.rms, got.unstable);
                end else begin
                    want = rms_due.pop_front();
                    if (got.rms !== want.rms) begin
                        failures++;
                        $display("%0t: rms mismatch, expected %0d, got %0d",
                                 $time, want.rms, got.rms);
                    end
                    if (got.unstable !== want.unstable) begin
                        failures++;
                        $display("%0t: unstable mismatch, expected %0b, got %0b",
                                 $time, want.unstable, got.unstable);
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tuser);
        end
        pending = rms_due.size();
    end

endmodule

@@ tb/sliding_rms_stability_check_tb.sv @@
module sliding_rms_stability_check_tb;
    import srs_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_LIMIT  = {REG_STABILITY_LIMIT, 2'b00};
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 360;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int failures;
    int pending_results;
    int stall_cycles = 0;
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    always #2 aclk = ~aclk;

    sliding_rms_stability_check dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rms_window_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .failures (failures),
        .pending  (pending_results)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hold off the result channel on request, else drop ready now and then unless steady
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= 8);
        end
    end

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_sample(input logic [15:0] value, input logic starts_record);
        if (!steady && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= starts_record;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain(input int tail);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (tail) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        int          r;
        logic [15:0] v;
        r = $urandom_range(99);
        if (r < 45) begin
            v = 16'($urandom);
        end else if (r < 65) begin
            v = 16'($urandom_range(0, 600) - 300);
        end else if (r < 85) begin
            v = 16'($urandom_range(9000, 17000));
            if ($urandom_range(1))
                v = -v;
        end else begin
            case ($urandom_range(3))
                0:       v = 16'h8000;
                1:       v = 16'h7fff;
                2:       v = 16'h0000;
                default: v = 16'hffff;
            endcase
        end
        return v;
    endfunction

    initial begin
        int taken;
        int phase;
        int count;
        int r;
        logic [APB_DW-1:0] wl;
        logic [APB_DW-1:0] lim;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window of one at the reset threshold
        reg_write(ADDR_WINDOW, 1);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hffff, 1'b0);
        push_sample(16'd12868, 1'b0);
        push_sample(16'd12869, 1'b0);
        drain(1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h5555, 1'b0);

        drain(100);
        reg_write(ADDR_WINDOW, 0);
        reg_write(ADDR_LIMIT, 32767);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'haaaa, 1'b1);

        // restart in the middle of filling, with a zero threshold
        drain(100);
        reg_write(ADDR_WINDOW, 3);
        reg_write(ADDR_LIMIT, 0);
        push_sample(16'd100, 1'b0);
        push_sample(16'd200, 1'b0);
        push_sample(16'd300, 1'b1);
        push_sample(16'd400, 1'b0);
        push_sample(16'd500, 1'b0);
        push_sample(-16'sd600, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h0002, 1'b0);

        taken = 0;
        phase = 0;
        while (taken < RANDOM_ITEMS) begin
            drain(100);
            r = $urandom_range(99);
            if (r < 60)
                wl = $urandom_range(1, 8);
            else if (r < 80)
                wl = $urandom_range(9, 40);
            else if (r < 90)
                wl = 0;
            else
                wl = $urandom_range(41, 100);
            if (phase == 0)
                wl = 1;
            if (phase == 0 || $urandom_range(1))
                reg_write(ADDR_WINDOW, wl);
            r = $urandom_range(99);
            if (r < 15)
                lim = 0;
            else if (r < 30)
                lim = 32767;
            else
                lim = $urandom_range(0, 20000);
            reg_write(ADDR_LIMIT, lim);
            steady = (phase == 2);
            count = $urandom_range(40, 90);
            for (int i = 0; i < count; i++) begin
                if (phase == 0 && i == 5)
                    hold_request = 1'b1;
                if ($urandom_range(99) < 2)
                    drain(1);
                push_sample(pick_sample(), $urandom_range(99) < 3);
            end
            taken += count;
            phase++;
        end
        steady = 1'b0;

        // widest window, written exactly and above the maximum
        drain(100);
        reg_write(ADDR_WINDOW, 1024);
        reg_write(ADDR_LIMIT, 9000);
        repeat (20) push_sample(pick_sample(), 1'b0);
        drain(100);
        reg_write(ADDR_WINDOW, 2047);
        repeat (1040) push_sample(pick_sample(), 1'b0);

        drain(100);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
